[hdl/wps_pkg.sv]
// window placement search package
// types, constants and state codes; no dependencies
`default_nettype none
package wps_pkg;
  localparam int NUM_WINDOWS = 16;
  localparam int SLOT_BITS = 4;
  localparam int COORD_BITS = 11;
  localparam int CFG_BITS = 11;
  localparam int GRID = 10;
  localparam int FINE = 5;
  localparam int VB = COORD_BITS + 3;
  localparam int OVB = 2 * VB + SLOT_BITS + 2;
  localparam int SPB = 2 * VB + SLOT_BITS + 2;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CFG_SCREEN_WIDTH = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_COARSE_SET, ST_CAND, ST_WIN, ST_MULX, ST_MULY, ST_ACC,
    ST_DECIDE, ST_FINE_SET, ST_OUT
  } state_t;

  typedef struct packed {
    logic active;
    logic [COORD_BITS-1:0] x1, y1, x2, y2;
  } win_t;

  typedef struct packed {
    logic status;
    logic [COORD_BITS-1:0] left, top, right, bottom;
  } result_t;

  typedef struct packed {
    logic command;
    logic [SLOT_BITS-1:0] slot;
    logic slot_active;
    logic [COORD_BITS-1:0] rect_left, rect_top, rect_right, rect_bottom;
    logic [COORD_BITS-1:0] want_width, want_height;
  } item_t;

  function automatic logic signed [VB-1:0] seg_overlap(
      input logic signed [VB-1:0] a1, a2, b1, b2);
    logic signed [VB-1:0] r;
    if (a2 < b1 || b2 < a1) r = '0;
    else if (a1 <= b1 && a2 >= b2) r = b2 - b1;
    else if (b1 <= a1 && b2 >= a2) r = a2 - a1;
    else if (a1 <= b1 && b1 <= a2 && a2 <= b2) r = a2 - b1;
    else if (b1 <= a1 && a1 <= b2 && b2 <= a2) r = b2 - a1;
    else r = '0;
    return r;
  endfunction
endpackage
`default_nettype wire

[hdl/wps_if.sv]
// valid/ready channel interface carrying one word
// depends on nothing
`default_nettype none
interface wps_if #(parameter type word_t = logic) (input wire logic clk);
  logic valid;
  logic ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/window_placement_search.sv]
// window placement search top level: table, sequencer, shared overlap unit
// depends on wps_pkg and wps_if
//
// channel | dir | word
// in      | in  | item_t: command, slot, rect, want size
// out     | out | result_t: status, placed rectangle
// cfg     | in  | we, idx, wdata (screen size)
//
// a write, rejected or empty-table place item is answered from ST_SCAN,
// which loads the output register; a search visits ST_CAND and ST_DECIDE
// per candidate, with ST_WIN, ST_MULX, ST_MULY and ST_ACC per active and
// ST_WIN and ST_ACC per inactive table slot. reset clears the table valid
// bits at once. the result stays in the output register until taken; a new
// word is accepted only when the output is free and the search is idle
`default_nettype none
module window_placement_search import wps_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  wps_if.sink in,
  wps_if.source out,
  input wire logic cfg_we,
  input wire logic cfg_idx,
  input wire logic [CFG_BITS-1:0] cfg_wdata
);
  typedef logic signed [VB-1:0] v_t;
  state_t state, state_next;
  win_t table_q [NUM_WINDOWS];
  logic [CFG_BITS-1:0] sw, sh;
  item_t it;
  v_t lx, ly, cx, cy, sx2, sy1, sy2, c1x, c1y, c2x, c2y;
  logic [SLOT_BITS-1:0] wi;
  logic fine, first;
  v_t ovx, ovy, dx, dy;
  logic signed [OVB-1:0] ov, bov;
  logic signed [SPB-1:0] sp, bsp;
  logic signed [2*VB-1:0] prod_a, prod_b;
  v_t b0, b1, b2, b3;
  logic any;
  logic outv;
  result_t res;

  assign in.ready = (state == ST_IDLE) && !outv;
  assign out.valid = outv;
  assign out.data = res;

  always_comb begin
    any = 1'b0;
    for (int i = 0; i < NUM_WINDOWS; i++) any = any | table_q[i].active;
  end

  v_t svw, svh, ex, ey, w1, w2, w3, w4, ix, iy;
  always_comb begin
    svw = v_t'({1'b0, sw}); svh = v_t'({1'b0, sh});
    ex = cx + v_t'(GRID); if (ex > svw) ex = svw;
    ey = cy + v_t'(GRID); if (ey > svh) ey = svh;
    ex = (cx + ex) >>> 1; ey = (cy + ey) >>> 1;
    w1 = v_t'({1'b0, table_q[wi].x1}); w2 = v_t'({1'b0, table_q[wi].y1});
    w3 = v_t'({1'b0, table_q[wi].x2}); w4 = v_t'({1'b0, table_q[wi].y2});
    ix = (lx < svw - v_t'(GRID)) ? v_t'(GRID) : v_t'(0);
    iy = (ly < svh - v_t'(GRID)) ? v_t'(GRID) : v_t'(0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; outv <= 1'b0; sw <= CFG_BITS'(480); sh <= CFG_BITS'(272);
      for (int i = 0; i < NUM_WINDOWS; i++) table_q[i].active <= 1'b0;
      b0 <= '0; b1 <= '0; b2 <= '0; b3 <= '0; bov <= '0; bsp <= '0; first <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_idx == CFG_SCREEN_WIDTH) sw <= cfg_wdata;
      if (cfg_we && cfg_idx == CFG_SCREEN_HEIGHT) sh <= cfg_wdata;
      if (out.valid && out.ready) outv <= 1'b0;
      unique case (state)
        ST_IDLE: if (in.valid && in.ready) begin
          it <= in.data;
          lx <= v_t'({1'b0, in.data.want_width}); ly <= v_t'({1'b0, in.data.want_height});
        end
        ST_SCAN: begin
          if (it.command == CMD_WRITE) begin
            table_q[it.slot] <= '{it.slot_active, it.rect_left, it.rect_top,
                                  it.rect_right, it.rect_bottom};
            res <= '0;
            outv <= 1'b1;
          end else if (!(lx < svw && ly < svh)) begin
            res <= '{status: 1'b1, default: '0};
            outv <= 1'b1;
          end else if (!any) begin
            res <= '{1'b0, COORD_BITS'(ix), COORD_BITS'(iy), COORD_BITS'(ix + lx),
                     COORD_BITS'(iy + ly)};
            outv <= 1'b1;
          end else begin
            cx <= lx; cy <= ly; fine <= 1'b0; first <= 1'b1;
          end
        end
        ST_CAND: begin
          if (fine) begin
            c1x <= cx; c1y <= cy; c2x <= cx + lx; c2y <= cy + ly;
          end else begin
            c1x <= ex - lx; c1y <= ey - ly; c2x <= ex; c2y <= ey;
          end
          ov <= '0; sp <= '0; wi <= '0;
        end
        ST_WIN: begin
          ovx <= seg_overlap(w1, w3, c1x, c2x);
          ovy <= seg_overlap(w2, w4, c1y, c2y);
          dx <= ((w1 + w3) >>> 1) - ((c1x + c2x) >>> 1);
          dy <= ((w2 + w4) >>> 1) - ((c1y + c2y) >>> 1);
        end
        ST_MULX: begin prod_a <= ovx * ovy; prod_b <= dx * dx; end
        ST_MULY: begin
          ov <= ov + OVB'(prod_a); sp <= sp + SPB'(prod_b); prod_b <= dy * dy;
        end
        ST_ACC: begin
          if (table_q[wi].active) sp <= sp + SPB'(prod_b);
          wi <= wi + 1'b1;
        end
        ST_DECIDE: begin
          if (first || ov < bov || (ov == bov && sp > bsp)) begin
            b0 <= c1x; b1 <= c1y; b2 <= c2x; b3 <= c2y; bov <= ov; bsp <= sp;
            first <= 1'b0;
          end
          if (fine) begin
            if (cy + v_t'(1) < sy2) cy <= cy + v_t'(1);
            else begin cy <= sy1; cx <= cx + v_t'(1); end
          end else if (cy + v_t'(GRID) < svh) cy <= cy + v_t'(GRID);
          else begin cy <= ly; cx <= cx + v_t'(GRID); end
        end
        ST_FINE_SET: begin
          fine <= 1'b1; first <= 1'b1;
          cx <= (b0 - v_t'(FINE) < 0) ? v_t'(0) : b0 - v_t'(FINE);
          cy <= (b1 - v_t'(FINE) < 0) ? v_t'(0) : b1 - v_t'(FINE);
          sy1 <= (b1 - v_t'(FINE) < 0) ? v_t'(0) : b1 - v_t'(FINE);
          sx2 <= (b0 + v_t'(FINE) + lx > svw) ? svw - lx : b0 + v_t'(FINE);
          sy2 <= (b1 + v_t'(FINE) + ly > svh) ? svh - ly : b1 + v_t'(FINE);
        end
        ST_OUT: begin
          res <= '{1'b0, COORD_BITS'(b0), COORD_BITS'(b1), COORD_BITS'(b2),
                   COORD_BITS'(b3)};
          outv <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in.valid && in.ready) state_next = ST_SCAN;
      ST_SCAN: state_next = (it.command == CMD_WRITE || !(lx < svw && ly < svh) || !any)
                            ? ST_IDLE : ST_COARSE_SET;
      ST_COARSE_SET: state_next = (cx < svw && cy < svh) ? ST_CAND : ST_FINE_SET;
      ST_CAND: state_next = ST_WIN;
      ST_WIN: state_next = table_q[wi].active ? ST_MULX : ST_ACC;
      ST_MULX: state_next = ST_MULY;
      ST_MULY: state_next = ST_ACC;
      ST_ACC: state_next = (wi == SLOT_BITS'(NUM_WINDOWS - 1)) ? ST_DECIDE : ST_WIN;
      ST_DECIDE: begin
        if (fine) begin
          if (cy + v_t'(1) < sy2) state_next = ST_CAND;
          else state_next = (cx + v_t'(1) < sx2) ? ST_CAND : ST_OUT;
        end else if (cy + v_t'(GRID) < svh) state_next = ST_CAND;
        else state_next = (cx + v_t'(GRID) < svw) ? ST_CAND : ST_FINE_SET;
      end
      ST_FINE_SET: state_next = ST_COARSE_SET;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_COARSE_SET && fine)
      state_next = (cx < sx2 && cy < sy2) ? ST_CAND : ST_OUT;
  end
endmodule
`default_nettype wire

[test/wps_checker.sv]
// placement checker: watches the item, result and register ports of the block
// computes the expected placement per item and compares; depends on wps_pkg
`timescale 1ns / 100ps
`default_nettype none
module wps_checker import wps_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire item_t in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire result_t out_data,
  input wire logic cfg_we,
  input wire logic cfg_idx,
  input wire logic [CFG_BITS-1:0] cfg_wdata,
  output int fail_count,
  output int pending
);
  win_t wins[NUM_WINDOWS];
  int scr_w, scr_h;
  int best_r[4];
  longint best_ov, best_sp;
  bit first_try;
  result_t placements[$];

  function automatic int span_overlap(int a1, int a2, int b1, int b2);
    if (a2 < b1 || b2 < a1) return 0;
    if (a1 <= b1 && a2 >= b2) return b2 - b1;
    if (b1 <= a1 && b2 >= a2) return a2 - a1;
    if (a1 <= b1 && b1 <= a2 && a2 <= b2) return a2 - b1;
    if (b1 <= a1 && a1 <= b2 && b2 <= a2) return b2 - a1;
    return 0;
  endfunction

  function automatic void score_spot(int x1, int y1, int x2, int y2);
    longint ov, sp, dx, dy;
    int wx1, wy1, wx2, wy2;
    ov = 0;
    sp = 0;
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      if (wins[i].active) begin
        wx1 = int'(wins[i].x1);
        wy1 = int'(wins[i].y1);
        wx2 = int'(wins[i].x2);
        wy2 = int'(wins[i].y2);
        ov += longint'(span_overlap(wx1, wx2, x1, x2)) *
              longint'(span_overlap(wy1, wy2, y1, y2));
        dx = longint'((wx1 + wx2) / 2) - longint'((x1 + x2) / 2);
        dy = longint'((wy1 + wy2) / 2) - longint'((y1 + y2) / 2);
        sp += dx * dx + dy * dy;
      end
    end
    if (first_try || ov < best_ov || (ov == best_ov && sp > best_sp)) begin
      best_r[0] = x1;
      best_r[1] = y1;
      best_r[2] = x2;
      best_r[3] = y2;
      best_ov = ov;
      best_sp = sp;
      first_try = 0;
    end
  endfunction

  function automatic result_t place_window(item_t it);
    result_t res;
    int lx, ly, ex, ey, sx1, sx2, sy1, sy2;
    int r[4];
    bit any;
    res = '0;
    r = '{0, 0, 0, 0};
    if (it.command == CMD_WRITE) begin
      wins[it.slot] = '{it.slot_active, it.rect_left, it.rect_top,
                        it.rect_right, it.rect_bottom};
      return res;
    end
    lx = int'(it.want_width);
    ly = int'(it.want_height);
    if (!(lx < scr_w && ly < scr_h)) begin
      res.status = 1'b1;
      return res;
    end
    any = 0;
    for (int i = 0; i < NUM_WINDOWS; i++) if (wins[i].active) any = 1;
    if (!any) begin
      r[0] = (lx < scr_w - GRID) ? GRID : 0;
      r[1] = (ly < scr_h - GRID) ? GRID : 0;
      r[2] = r[0] + lx;
      r[3] = r[1] + ly;
    end else begin
      first_try = 1;
      for (int cx = lx; cx < scr_w; cx += GRID)
        for (int cy = ly; cy < scr_h; cy += GRID) begin
          ex = cx + GRID;
          if (ex > scr_w) ex = scr_w;
          ey = cy + GRID;
          if (ey > scr_h) ey = scr_h;
          ex = (cx + ex) / 2;
          ey = (cy + ey) / 2;
          score_spot(ex - lx, ey - ly, ex, ey);
        end
      sx1 = best_r[0] - FINE;
      if (sx1 < 0) sx1 = 0;
      sx2 = best_r[0] + FINE;
      if (sx2 + lx > scr_w) sx2 = scr_w - lx;
      sy1 = best_r[1] - FINE;
      if (sy1 < 0) sy1 = 0;
      sy2 = best_r[1] + FINE;
      if (sy2 + ly > scr_h) sy2 = scr_h - ly;
      first_try = 1;
      for (int cx = sx1; cx < sx2; cx++)
        for (int cy = sy1; cy < sy2; cy++)
          score_spot(cx, cy, cx + lx, cy + ly);
      r = best_r;
    end
    res.left = r[0][COORD_BITS-1:0];
    res.top = r[1][COORD_BITS-1:0];
    res.right = r[2][COORD_BITS-1:0];
    res.bottom = r[3][COORD_BITS-1:0];
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NUM_WINDOWS; i++) wins[i] = '0;
      best_r = '{0, 0, 0, 0};
      best_ov = 0;
      best_sp = 0;
      first_try = 1;
      scr_w = 480;
      scr_h = 272;
      placements.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SCREEN_WIDTH) scr_w = int'(cfg_wdata);
        else scr_h = int'(cfg_wdata);
      end
      if (in_valid && in_ready) placements.push_back(place_window(in_data));
      if (out_valid && out_ready) begin
        if (placements.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          exp_r = placements.pop_front();
          if (out_data.status !== exp_r.status)
            report("status", out_data.status, exp_r.status);
          if (out_data.left !== exp_r.left) report("left", out_data.left, exp_r.left);
          if (out_data.top !== exp_r.top) report("top", out_data.top, exp_r.top);
          if (out_data.right !== exp_r.right)
            report("right", out_data.right, exp_r.right);
          if (out_data.bottom !== exp_r.bottom)
            report("bottom", out_data.bottom, exp_r.bottom);
        end
      end
    end
    pending <= placements.size();
  end
endmodule
`default_nettype wire

[test/tb_window_placement_search.sv]
// testbench top for window_placement_search: clock, reset, stimulus, verdict
// depends on wps_pkg, wps_if, the block and wps_checker
`timescale 1ns / 100ps
`default_nettype none
module tb_window_placement_search;
  import wps_pkg::*;
  localparam int CYCLE_LIMIT = 8000000;

  logic clk, rst;
  logic cfg_we, cfg_idx;
  logic [CFG_BITS-1:0] cfg_wdata;
  int fail_count, pending;
  bit quiet, hold_req;
  int cur_w, cur_h;

  wps_if #(.word_t(item_t)) in_ch (clk);
  wps_if #(.word_t(result_t)) out_ch (clk);

  window_placement_search uut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  wps_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    int n;
    n = 0;
    forever begin
      @(posedge clk);
      n++;
      if (n > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 0;
        repeat (300) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ch.ready = 1;
      end
    end
  end

  task automatic send_word(item_t it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain;
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_screen(int w, int h);
    @(negedge clk);
    cfg_we = 1;
    cfg_idx = CFG_SCREEN_WIDTH;
    cfg_wdata = w[CFG_BITS-1:0];
    @(negedge clk);
    cfg_idx = CFG_SCREEN_HEIGHT;
    cfg_wdata = h[CFG_BITS-1:0];
    @(negedge clk);
    cfg_we = 0;
    cur_w = w;
    cur_h = h;
  endtask

  function automatic item_t mk_write(int s, bit act, int l, int t, int r, int b);
    item_t it;
    it = item_t'($urandom());
    it.command = CMD_WRITE;
    it.slot = s[SLOT_BITS-1:0];
    it.slot_active = act;
    it.rect_left = l[COORD_BITS-1:0];
    it.rect_top = t[COORD_BITS-1:0];
    it.rect_right = r[COORD_BITS-1:0];
    it.rect_bottom = b[COORD_BITS-1:0];
    return it;
  endfunction

  function automatic item_t mk_place(int w, int h);
    item_t it;
    it = item_t'({$urandom(), $urandom()});
    it.command = ~CMD_WRITE;
    it.want_width = w[COORD_BITS-1:0];
    it.want_height = h[COORD_BITS-1:0];
    return it;
  endfunction

  function automatic item_t mk_random;
    int x1, y1;
    if ($urandom_range(0, 9) < 4) begin
      if ($urandom_range(0, 7) == 0)
        return mk_write($urandom_range(0, 15), $urandom_range(0, 1),
                        $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 2047), $urandom_range(0, 2047));
      x1 = $urandom_range(0, cur_w);
      y1 = $urandom_range(0, cur_h);
      return mk_write($urandom_range(0, 15), $urandom_range(0, 3) != 0, x1, y1,
                      x1 + $urandom_range(0, 20), y1 + $urandom_range(0, 20));
    end
    if ($urandom_range(0, 9) == 0)
      return mk_place($urandom_range(0, 2047), $urandom_range(0, 2047));
    return mk_place($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
  endfunction

  initial begin
    rst = 1;
    quiet = 0;
    hold_req = 0;
    cfg_we = 0;
    cfg_idx = CFG_SCREEN_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 0;
    in_ch.data = '0;
    cur_w = 480;
    cur_h = 272;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty table at reset sizes, inset and no-inset corners, too large
    send_word(mk_place(469, 261));
    send_word(mk_place(470, 262));
    send_word(mk_place(480, 100));
    send_word(mk_place(2047, 2047));
    send_word(mk_write(15, 0, 2047, 2047, 2047, 2047));
    // backed-up output while writes keep coming
    hold_req = 1;
    for (int i = 0; i < 6; i++) send_word(mk_write(i, 0, 0, 0, 0, 0));
    send_word(mk_write(0, 1, 100, 50, 200, 150));
    send_word(mk_write(3, 1, 300, 200, 250, 180));
    send_word(mk_place(0, 0));
    send_word(mk_place(475, 265));
    drain();

    set_screen(16, 16);
    send_word(mk_write(0, 1, 0, 0, 15, 15));
    send_word(mk_place(15, 15));
    send_word(mk_place(5, 7));
    send_word(mk_place(16, 0));
    send_word(mk_place(0, 16));
    drain();

    set_screen(1024, 1024);
    send_word(mk_place(1020, 1017));
    send_word(mk_place(1023, 1023));
    send_word(mk_place(1024, 10));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_screen($urandom_range(16, 45), $urandom_range(16, 45));
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 25; i++) send_word(mk_random());
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hdl/wps_pkg.sv
hdl/wps_if.sv
hdl/window_placement_search.sv
test/wps_checker.sv
test/tb_window_placement_search.sv
